/* sv/sqb_pkg.sv */
// sqb_pkg: shared constants, codes and control structs of the sprite quad batcher.
// Used by sqb_seq and sprite_quad_batcher_core; no dependencies.
`timescale 1ns / 1ps

package sqb_pkg;

  localparam int MAX_QUADS = 1024;
  localparam int TEX_SLOTS = 16;

  // slot counter holds 0..TEX_SLOTS, slot index 0..TEX_SLOTS-1
  localparam int CNT_W  = $clog2(TEX_SLOTS + 1);
  localparam int IDX_W  = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
  localparam int QCNT_W = $clog2(MAX_QUADS + 1);

  localparam int HANDLE_W = 32;
  localparam int IN_W     = 144;
  localparam int OUT_W    = 136;
  localparam int KIND_W   = 2;

  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd2;

  // corner order (-,-) (+,-) (+,+) (-,+); a set bit means the plus side
  localparam logic [3:0] CORNER_SX = 4'b0110;
  localparam logic [3:0] CORNER_SY = 4'b1100;

  typedef logic [3:0] upc_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_IN,
    C_IDX_END,
    C_MATCH,
    C_FULL,
    C_CORNER_LAST,
    C_QFULL,
    C_PRE
  } cond_t;

  typedef enum logic [1:0] {
    E_NONE,
    E_VTX,
    E_BIND,
    E_DRAW
  } emit_t;

  typedef struct packed {
    logic  accept;
    cond_t cond;
    upc_t  jmp;
    upc_t  nxt;
    emit_t emit;
    logic  idx_clr;
    logic  idx_inc;
    logic  slot_idx;
    logic  slot_used;
    logic  ram_we;
    logic  used_inc;
    logic  quad_inc;
    logic  batch_clr;
    logic  corner_inc;
    logic  pre_ld;
    logic  pre_clr;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic idx_end;
    logic match;
    logic full;
    logic corner_last;
    logic qfull;
    logic pre;
    logic out_free;
  } cond_vec_t;

  typedef struct packed {
    uword_t w;
    logic   fire;
    logic   taken;
  } seq_out_t;

endpackage

/* sv/sqb_ram.sv */
// sqb_ram: generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sqb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/sqb_seq.sv */
// sqb_seq: microcode sequencer; program table, step counter and jump conditions.
// Depends on sqb_pkg.
`timescale 1ns / 1ps

module sqb_seq (
  input  logic              clk,
  input  logic              rst,
  input  sqb_pkg::cond_vec_t cv,
  output sqb_pkg::seq_out_t  so
);

  localparam sqb_pkg::upc_t P_IDLE = 4'd0;
  localparam sqb_pkg::upc_t P_CHK  = 4'd1;
  localparam sqb_pkg::upc_t P_CMP  = 4'd2;
  localparam sqb_pkg::upc_t P_MISS = 4'd3;
  localparam sqb_pkg::upc_t P_INS  = 4'd4;
  localparam sqb_pkg::upc_t P_VTX  = 4'd5;
  localparam sqb_pkg::upc_t P_QCHK = 4'd6;
  localparam sqb_pkg::upc_t P_FCHK = 4'd7;
  localparam sqb_pkg::upc_t P_BIND = 4'd8;
  localparam sqb_pkg::upc_t P_DRAW = 4'd9;

  function automatic sqb_pkg::uword_t ucode(sqb_pkg::upc_t a);
    sqb_pkg::uword_t w;
    w      = '0;
    w.cond = sqb_pkg::C_NEVER;
    w.emit = sqb_pkg::E_NONE;
    w.jmp  = P_IDLE;
    w.nxt  = P_IDLE;
    unique case (a)
      P_IDLE: begin
        w.accept  = 1'b1;
        w.cond    = sqb_pkg::C_IN;
        w.jmp     = P_CHK;
        w.nxt     = P_IDLE;
        w.idx_clr = 1'b1;
        w.pre_clr = 1'b1;
      end
      // ram read of slot idx is in flight, data valid in the next step
      P_CHK: begin
        w.cond = sqb_pkg::C_IDX_END;
        w.jmp  = P_MISS;
        w.nxt  = P_CMP;
      end
      P_CMP: begin
        w.cond     = sqb_pkg::C_MATCH;
        w.jmp      = P_VTX;
        w.nxt      = P_CHK;
        w.slot_idx = 1'b1;
        w.idx_inc  = 1'b1;
      end
      P_MISS: begin
        w.cond    = sqb_pkg::C_FULL;
        w.jmp     = P_FCHK;
        w.nxt     = P_INS;
        w.idx_clr = 1'b1;
        w.pre_ld  = 1'b1;
      end
      P_INS: begin
        w.nxt       = P_VTX;
        w.ram_we    = 1'b1;
        w.slot_used = 1'b1;
        w.used_inc  = 1'b1;
      end
      P_VTX: begin
        w.emit       = sqb_pkg::E_VTX;
        w.cond       = sqb_pkg::C_CORNER_LAST;
        w.jmp        = P_QCHK;
        w.nxt        = P_VTX;
        w.corner_inc = 1'b1;
      end
      P_QCHK: begin
        w.cond     = sqb_pkg::C_QFULL;
        w.jmp      = P_FCHK;
        w.nxt      = P_IDLE;
        w.quad_inc = 1'b1;
        w.idx_clr  = 1'b1;
        w.pre_clr  = 1'b1;
      end
      P_FCHK: begin
        w.cond = sqb_pkg::C_IDX_END;
        w.jmp  = P_DRAW;
        w.nxt  = P_BIND;
      end
      P_BIND: begin
        w.emit    = sqb_pkg::E_BIND;
        w.nxt     = P_FCHK;
        w.idx_inc = 1'b1;
      end
      P_DRAW: begin
        w.emit      = sqb_pkg::E_DRAW;
        w.cond      = sqb_pkg::C_PRE;
        w.jmp       = P_INS;
        w.nxt       = P_IDLE;
        w.batch_clr = 1'b1;
      end
      default: begin
        w.nxt = P_IDLE;
      end
    endcase
    return w;
  endfunction

  sqb_pkg::upc_t   pc;
  sqb_pkg::upc_t   pc_next;
  sqb_pkg::uword_t w;
  logic            taken;
  logic            stall;

  always_comb begin
    w = ucode(pc);
    case (w.cond)
      sqb_pkg::C_IN:          taken = cv.in_valid;
      sqb_pkg::C_IDX_END:     taken = cv.idx_end;
      sqb_pkg::C_MATCH:       taken = cv.match;
      sqb_pkg::C_FULL:        taken = cv.full;
      sqb_pkg::C_CORNER_LAST: taken = cv.corner_last;
      sqb_pkg::C_QFULL:       taken = cv.qfull;
      sqb_pkg::C_PRE:         taken = cv.pre;
      default:                taken = 1'b0;
    endcase
    // a result step waits for the output register to be free
    stall   = (w.emit != sqb_pkg::E_NONE) && !cv.out_free;
    pc_next = stall ? pc : (taken ? w.jmp : w.nxt);
    so.w     = w;
    so.fire  = !stall;
    so.taken = taken;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= P_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* sv/sprite_quad_batcher_core.sv */
// sprite_quad_batcher_core: top level; slot table, batch counters, corner datapath.
// Depends on sqb_pkg, sqb_ram and sqb_seq.
`timescale 1ns / 1ps

// channel | dir | fields
// s_*     | in  | sprite request: tdata only
// m_*     | out | result: tdata, tuser = kind, tlast = last
//
// per sprite without output stalls, a hit on slot k searches slots 0..k and a
// miss searches all n slots in use; a flush adds one ram read and one
// bind transfer per slot, then the draw. the slot search reads one slot ram
// entry per check and compare step pair. reset (rst, synchronous) empties the batch and
// the output register; slot ram contents are left as they are. a result
// waiting in the output register stalls the program only at result steps.

module sprite_quad_batcher_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // pos_x, pos_y, pos_z, size_w, size_h, color_rgba, tex_handle_in, zero pad
  input  logic [sqb_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // vertex_x, vertex_y, vertex_z, vertex_color, tex_u, tex_v, slot_index,
  // bound_handle, batch_quads, zero pad
  output logic [sqb_pkg::OUT_W-1:0]   m_tdata,
  // kind
  output logic [sqb_pkg::KIND_W-1:0]  m_tuser,
  output logic                        m_tlast
);

  function automatic logic signed [15:0] corner_coord(
    input logic signed [15:0] c,
    input logic               plus,
    input logic        [14:0] size
  );
    logic signed [18:0] twice;
    logic signed [18:0] sz;
    logic signed [17:0] half;
    logic signed [15:0] q;
    sz    = signed'({4'b0, size});
    twice = signed'({c[15], c[15], c, 1'b0}) + (plus ? sz : -sz);
    half  = twice[18:1];
    if (half > 18'sd32767) begin
      q = 16'sh7fff;
    end else if (half < -18'sd32768) begin
      q = -16'sh8000;
    end else begin
      q = half[15:0];
    end
    return q;
  endfunction

  sqb_pkg::cond_vec_t cv;
  sqb_pkg::seq_out_t  so;

  // latched request
  logic signed [15:0]          px, py, pz;
  logic        [14:0]          sw, sh;
  logic        [31:0]          col;
  logic [sqb_pkg::HANDLE_W-1:0] handle;

  logic [sqb_pkg::CNT_W-1:0]   idx;
  logic [sqb_pkg::CNT_W-1:0]   used;
  logic [sqb_pkg::QCNT_W-1:0]  quads;
  logic [sqb_pkg::IDX_W-1:0]   slot;
  logic [1:0]                  corner;
  logic                        pre;

  logic [sqb_pkg::IDX_W-1:0]    ram_addr;
  logic [sqb_pkg::HANDLE_W-1:0] ram_rdata;
  logic                         ram_we;
  logic                         in_xfer;
  logic                         out_free;
  logic                         emit_now;

  // output register fields
  logic [sqb_pkg::KIND_W-1:0] o_kind;
  logic signed [15:0]         o_x, o_y, o_z;
  logic [31:0]                o_col;
  logic                       o_u, o_v;
  logic [3:0]                 o_slot;
  logic [31:0]                o_bound;
  logic [10:0]                o_batch;
  logic                       o_last;

  assign s_tready = so.w.accept && !rst;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ram_we   = so.fire && so.w.ram_we;
  assign ram_addr = so.w.ram_we ? used[sqb_pkg::IDX_W-1:0] : idx[sqb_pkg::IDX_W-1:0];
  assign emit_now = so.fire && (so.w.emit != sqb_pkg::E_NONE);

  always_comb begin
    cv.in_valid    = s_tvalid;
    cv.idx_end     = idx >= used;
    cv.match       = ram_rdata == handle;
    cv.full        = used >= sqb_pkg::CNT_W'(sqb_pkg::TEX_SLOTS);
    cv.corner_last = corner == 2'd3;
    cv.qfull       = quads >= sqb_pkg::QCNT_W'(sqb_pkg::MAX_QUADS - 1);
    cv.pre         = pre;
    cv.out_free    = out_free;
  end

  sqb_seq u_seq (
    .clk (clk),
    .rst (rst),
    .cv  (cv),
    .so  (so)
  );

  sqb_ram #(
    .WIDTH (sqb_pkg::HANDLE_W),
    .DEPTH (sqb_pkg::TEX_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (handle),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px     <= s_tdata[15:0];
      py     <= s_tdata[31:16];
      pz     <= s_tdata[47:32];
      sw     <= s_tdata[62:48];
      sh     <= s_tdata[77:63];
      col    <= s_tdata[109:78];
      handle <= s_tdata[141:110];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      used   <= '0;
      quads  <= '0;
      corner <= '0;
      pre    <= 1'b0;
    end else if (so.fire) begin
      if (so.w.idx_clr) begin
        idx <= '0;
      end else if (so.w.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (so.w.batch_clr) begin
        used  <= '0;
        quads <= '0;
      end else begin
        if (so.w.used_inc) begin
          used <= used + 1'b1;
        end
        if (so.w.quad_inc) begin
          quads <= quads + 1'b1;
        end
      end
      if (so.w.corner_inc) begin
        corner <= corner + 1'b1;
      end
      if (so.w.pre_clr) begin
        pre <= 1'b0;
      end else if (so.w.pre_ld) begin
        pre <= so.taken;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (so.fire) begin
      if (so.w.slot_idx) begin
        slot <= idx[sqb_pkg::IDX_W-1:0];
      end else if (so.w.slot_used) begin
        slot <= used[sqb_pkg::IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_now) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      o_x     <= '0;
      o_y     <= '0;
      o_z     <= '0;
      o_col   <= '0;
      o_u     <= 1'b0;
      o_v     <= 1'b0;
      o_slot  <= '0;
      o_bound <= '0;
      o_batch <= '0;
      o_last  <= 1'b0;
      case (so.w.emit)
        sqb_pkg::E_VTX: begin
          o_kind <= sqb_pkg::KIND_VERTEX;
          o_x    <= corner_coord(px, sqb_pkg::CORNER_SX[corner], sw);
          o_y    <= corner_coord(py, sqb_pkg::CORNER_SY[corner], sh);
          o_z    <= pz;
          o_col  <= col;
          o_u    <= sqb_pkg::CORNER_SX[corner];
          o_v    <= sqb_pkg::CORNER_SY[corner];
          o_slot <= 4'(slot);
          // the fourth corner ends the item unless the batch fills up
          o_last <= cv.corner_last && !cv.qfull;
        end
        sqb_pkg::E_BIND: begin
          o_kind  <= sqb_pkg::KIND_BIND;
          o_slot  <= 4'(idx);
          o_bound <= ram_rdata;
        end
        default: begin
          o_kind  <= sqb_pkg::KIND_DRAW;
          o_batch <= 11'(quads);
          o_last  <= !pre;
        end
      endcase
    end
  end

  assign m_tdata = {7'b0, o_batch, o_bound, o_slot, o_v, o_u, o_col, o_z, o_y, o_x};
  assign m_tuser = o_kind;
  assign m_tlast = o_last;

endmodule

/* tb/tb.sv */
// tb: self-checking bench for sprite_quad_batcher_core, with an in-bench batch predictor.
// Depends on sqb_pkg and the core RTL; exercises slot lookup, slot-table flushes and corner math.
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 300;
  localparam int MAX_PRINTS   = 40;
  // corner order (-,-) (+,-) (+,+) (-,+); bit set means plus side
  localparam logic [3:0] PLUS_X = 4'b0110;
  localparam logic [3:0] PLUS_Y = 4'b1100;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [14:0] size_w;
    logic [14:0] size_h;
    logic [31:0] color;
    logic [31:0] handle;
  } sprite_t;

  typedef struct packed {
    logic [sqb_pkg::KIND_W-1:0] kind;
    logic [15:0]                vx;
    logic [15:0]                vy;
    logic [15:0]                vz;
    logic [31:0]                color;
    logic                       u;
    logic                       v;
    logic [3:0]                 slot;
    logic [31:0]                handle;
    logic [10:0]                quads;
    logic                       last;
  } result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [sqb_pkg::IN_W-1:0]   s_tdata = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [sqb_pkg::OUT_W-1:0]  m_tdata;
  logic [sqb_pkg::KIND_W-1:0] m_tuser;
  logic                       m_tlast;

  sprite_quad_batcher_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] slot_handle [sqb_pkg::TEX_SLOTS];
  int          slots_taken = 0;
  int          quads_in_batch = 0;
  result_t     step_results[$];
  result_t     out_stream_q[$];

  int n_items = 0;
  int n_results = 0;
  int n_vertices = 0;
  int n_binds = 0;
  int n_draws = 0;
  int n_slot_flushes = 0;
  int n_quad_flushes = 0;
  int err_count = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  result_t want;

  function automatic logic [15:0] corner_coord(logic [15:0] centre, logic plus,
                                               logic [14:0] size);
    int sum;
    sum = 2 * int'($signed(centre)) + (plus ? int'(size) : -int'(size));
    sum = sum >>> 1;
    if (sum > 32767) sum = 32767;
    else if (sum < -32768) sum = -32768;
    return sum[15:0];
  endfunction

  function void flush_batch();
    result_t r;
    for (int i = 0; i < slots_taken && i < sqb_pkg::TEX_SLOTS; i++) begin
      r = '0;
      r.kind = sqb_pkg::KIND_BIND;
      r.slot = 4'(i);
      r.handle = slot_handle[i];
      step_results = {step_results, r};
    end
    r = '0;
    r.kind = sqb_pkg::KIND_DRAW;
    r.quads = 11'(quads_in_batch);
    step_results = {step_results, r};
    slots_taken = 0;
    quads_in_batch = 0;
  endfunction

  // results caused by one accepted sprite, appended to the expected stream
  function void batch_sprite(sprite_t sp);
    result_t r;
    int      slot;
    bit      hit;
    slot = 0;
    hit = 1'b0;
    step_results.delete();
    for (int i = 0; i < slots_taken && i < sqb_pkg::TEX_SLOTS; i++) begin
      if (slot_handle[i] == sp.handle) begin
        slot = i;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (slots_taken >= sqb_pkg::TEX_SLOTS) begin
        flush_batch();
        n_slot_flushes++;
      end
      slot = slots_taken;
      slot_handle[slot] = sp.handle;
      slots_taken++;
    end
    for (int c = 0; c < 4; c++) begin
      r = '0;
      r.kind = sqb_pkg::KIND_VERTEX;
      r.vx = corner_coord(sp.pos_x, PLUS_X[c], sp.size_w);
      r.vy = corner_coord(sp.pos_y, PLUS_Y[c], sp.size_h);
      r.vz = sp.pos_z;
      r.color = sp.color;
      r.u = PLUS_X[c];
      r.v = PLUS_Y[c];
      r.slot = 4'(slot);
      step_results = {step_results, r};
    end
    quads_in_batch++;
    if (quads_in_batch >= sqb_pkg::MAX_QUADS) begin
      flush_batch();
      n_quad_flushes++;
    end
    r = step_results[step_results.size() - 1];
    r.last = 1'b1;
    step_results[step_results.size() - 1] = r;
    foreach (step_results[k]) out_stream_q = {out_stream_q, step_results[k]};
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'h7fff - 16'($urandom_range(0, 15));
      1: return 16'h8000 + 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 15'h7fff;
      1, 2, 3, 4: return 15'($urandom_range(0, 255));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic sprite_t rand_sprite(logic [31:0] handle);
    sprite_t sp;
    sp.pos_x = rand_coord();
    sp.pos_y = rand_coord();
    sp.pos_z = 16'($urandom);
    sp.size_w = rand_size();
    sp.size_h = rand_size();
    sp.color = $urandom;
    sp.handle = handle;
    return sp;
  endfunction

  // one sprite transfer; valid is left high so a following call keeps streaming
  task automatic send_sprite(sprite_t sp);
    @(negedge clk);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 29) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, sp.handle, sp.color, sp.size_h, sp.size_w,
                sp.pos_z, sp.pos_y, sp.pos_x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    batch_sprite(sp);
    n_items++;
  endtask

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                n_results, name, got, exp_val));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (out_stream_q.size() == 0) begin
        report_mismatch($sformatf("result %0d of kind %0d with nothing expected",
                                  n_results, m_tuser));
      end else begin
        want = out_stream_q.pop_front();
        check_field("kind", m_tuser, want.kind);
        check_field("vertex_x", m_tdata[15:0], want.vx);
        check_field("vertex_y", m_tdata[31:16], want.vy);
        check_field("vertex_z", m_tdata[47:32], want.vz);
        check_field("vertex_color", m_tdata[79:48], want.color);
        check_field("tex_u", m_tdata[80], want.u);
        check_field("tex_v", m_tdata[81], want.v);
        check_field("slot_index", m_tdata[85:82], want.slot);
        check_field("bound_handle", m_tdata[117:86], want.handle);
        check_field("batch_quads", m_tdata[128:118], want.quads);
        check_field("last", m_tlast, want.last);
        case (want.kind)
          sqb_pkg::KIND_VERTEX: n_vertices++;
          sqb_pkg::KIND_BIND:   n_binds++;
          default:              n_draws++;
        endcase
      end
      n_results++;
    end
  end

  // result side ready, with random stalls and requested long hold-offs
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 29);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // field extremes, saturation, floor rounding, alternating bit patterns
  task automatic test_extremes();
    sprite_t sp;
    sp = '0;
    send_sprite(sp);
    sp = '{16'h7fff, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff, 32'hffffffff, 32'hffffffff};
    send_sprite(sp);
    sp = '{16'h8000, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff, 32'h0, 32'hffffffff};
    send_sprite(sp);
    // odd sizes around a negative centre round toward minus infinity
    sp = '{16'hfffd, 16'h0003, 16'h1234, 15'd5, 15'd7, 32'h80402010, 32'h1};
    send_sprite(sp);
    // corners just past the positive and negative limits
    sp = '{16'h7ff0, 16'h8001, 16'h0000, 15'h0021, 15'h0003, 32'h01020304, 32'h1};
    send_sprite(sp);
    sp = '{16'h5555, 16'haaaa, 16'h5555, 15'h2aaa, 15'h5555, 32'h5555aaaa, 32'haaaa5555};
    send_sprite(sp);
    sp = '{16'haaaa, 16'h5555, 16'haaaa, 15'h5555, 15'h2aaa, 32'haaaa5555, 32'h5555aaaa};
    send_sprite(sp);
    sp = '{16'h0001, 16'hffff, 16'hffff, 15'd1, 15'd1, 32'hffffffff, 32'h0};
    send_sprite(sp);
  endtask

  // fill every slot, then one more new handle forces a flush
  task automatic test_slot_overflow();
    int k;
    k = 0;
    while (slots_taken < sqb_pkg::TEX_SLOTS) begin
      send_sprite(rand_sprite(32'h100 + k));
      k++;
    end
    send_sprite(rand_sprite(32'hcafe0000));
    send_sprite(rand_sprite(32'hcafe0000));
    send_sprite(rand_sprite(32'h100));
  endtask

  task automatic test_random();
    logic [31:0] pool [20];
    logic [31:0] h;
    foreach (pool[i]) pool[i] = $urandom;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 150 && n < 210);
      case ($urandom_range(0, 9))
        0, 1: h = $urandom;
        2: h = $urandom_range(0, 1) ? 32'hffffffff : 32'h0;
        default: h = pool[$urandom_range(0, 19)];
      endcase
      send_sprite(rand_sprite(h));
    end
    no_idle = 1'b0;
  endtask

  // results held off while sprites keep coming, so the input side stalls
  task automatic test_backpressure();
    hold_req++;
    for (int n = 0; n < 40; n++)
      send_sprite(rand_sprite(32'h200 + $urandom_range(0, 17)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_slot_overflow();
    test_random();
    test_backpressure();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (out_stream_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d sprites sent; %0d vertex, %0d bind and %0d draw results checked",
             n_items, n_vertices, n_binds, n_draws);
    $display("flushes: %0d on a full slot table, %0d on the quad limit; %0d mismatches",
             n_slot_flushes, n_quad_flushes, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
